[src/ptp_pkg.sv]
`timescale 1ns / 1ps

package ptp_pkg;

    // Field and datapath widths
    localparam int COORD_W            = 32;
    localparam int COEF_W             = 16;
    localparam int ROW_W              = 3 * COEF_W;
    localparam int PROD_W             = COORD_W + COEF_W;
    localparam int ACC_W              = PROD_W + 2;
    localparam int NUM_W              = 2 * COORD_W;
    localparam int DEN_W              = COORD_W + 1;
    localparam int COEF_FRAC_BITS_DEF = 12;

    // Divider shape: quotient magnitude bits, bits retired per stage
    localparam int DIV_Q_W            = COORD_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_Q_W / DIV_BITS_PER_STAGE;

    // Configuration port
    localparam int CFG_AW  = 6;
    localparam int CFG_DW  = 64;
    localparam int REG_IDX_W = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW_Z = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_X    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_DEPTH = 3'd7;

    // Mode codes; the spare code runs transform then project
    localparam logic [1:0] MODE_XFORM_ONLY = 2'd0;
    localparam logic [1:0] MODE_PROJ_ONLY  = 2'd1;
    localparam logic [1:0] MODE_XFORM_PROJ = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ROW_W-1:0] coef_x;
        logic [ROW_W-1:0] coef_y;
        logic [ROW_W-1:0] coef_z;
        t_coord           shift_x;
        t_coord           shift_y;
        t_coord           shift_z;
        t_coord           depth;
    } t_cfg;

    // Point and flags carried alongside the divider
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   sat;
        logic   proj;
        logic   den_zero;
        logic   last;
    } t_side;

endpackage

[src/ptp_xform.sv]
`timescale 1ns / 1ps

module ptp_xform #(
    parameter int COEF_FRAC_BITS = ptp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ptp_pkg::t_coord                     i_x,
    input  ptp_pkg::t_coord                     i_y,
    input  ptp_pkg::t_coord                     i_z,
    input  logic                                i_last,
    input  ptp_pkg::t_cfg                       i_cfg,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ptp_pkg::t_side                      o_side,
    output logic signed [ptp_pkg::NUM_W-1:0]    o_num_x,
    output logic signed [ptp_pkg::NUM_W-1:0]    o_num_y,
    output logic signed [ptp_pkg::DEN_W-1:0]    o_den
);

    localparam int NS    = 3;
    localparam int ACC_W = ptp_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(ptp_pkg::t_coord'(32'h7fffffff));
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(ptp_pkg::t_coord'(32'h80000000));

    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    logic signed [ptp_pkg::PROD_W-1:0] w_prod [3][3];
    logic signed [ptp_pkg::PROD_W-1:0] r_prod [3][3];
    ptp_pkg::t_coord                   w_pin  [3];
    ptp_pkg::t_coord                   r_p0   [3];
    logic                              r_last0;
    logic [ptp_pkg::ROW_W-1:0]         w_row  [3];
    ptp_pkg::t_coord                   w_shift[3];

    ptp_pkg::t_coord n_q [3];
    ptp_pkg::t_coord r_q [3];
    logic            n_sat;
    logic            r_sat1;
    logic            r_proj1;
    logic            r_last1;

    logic signed [ptp_pkg::DEN_W-1:0] n_den;
    ptp_pkg::t_side                   r_side;
    logic signed [ptp_pkg::NUM_W-1:0] r_num_x;
    logic signed [ptp_pkg::NUM_W-1:0] r_num_y;
    logic signed [ptp_pkg::DEN_W-1:0] r_den;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_en[NS] = !i_stall;
        for (int s = NS - 1; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    assign w_pin[0]   = i_x;
    assign w_pin[1]   = i_y;
    assign w_pin[2]   = i_z;
    assign w_row[0]   = i_cfg.coef_x;
    assign w_row[1]   = i_cfg.coef_y;
    assign w_row[2]   = i_cfg.coef_z;
    assign w_shift[0] = i_cfg.shift_x;
    assign w_shift[1] = i_cfg.shift_y;
    assign w_shift[2] = i_cfg.shift_z;

    // Stage 0: nine coordinate by coefficient products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_prod[k][j] = w_pin[k] * signed'(w_row[k][ptp_pkg::COEF_W*j +: ptp_pkg::COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_prod  <= w_prod;
            r_p0    <= w_pin;
            r_last0 <= i_last;
        end
    end

    // Stage 1: sum columns, add shift, round, rescale, clip; pick the raw point in project only
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] scl;
        logic                    xf;
        xf    = (i_cfg.mode != ptp_pkg::MODE_PROJ_ONLY);
        n_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            acc = ACC_W'(r_prod[0][j]) + ACC_W'(r_prod[1][j]) + ACC_W'(r_prod[2][j])
                + (ACC_W'(w_shift[j]) <<< COEF_FRAC_BITS)
                + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
            scl = acc >>> COEF_FRAC_BITS;
            if (!xf) begin
                n_q[j] = r_p0[j];
            end else if (scl > ACC_MAX) begin
                n_q[j] = ptp_pkg::t_coord'(32'h7fffffff);
                n_sat  = 1'b1;
            end else if (scl < ACC_MIN) begin
                n_q[j] = ptp_pkg::t_coord'(32'h80000000);
                n_sat  = 1'b1;
            end else begin
                n_q[j] = scl[ptp_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_q     <= n_q;
            r_sat1  <= n_sat;
            r_proj1 <= (i_cfg.mode != ptp_pkg::MODE_XFORM_ONLY);
            r_last1 <= r_last0;
        end
    end

    // Stage 2: projection numerators and denominator
    assign n_den = ptp_pkg::DEN_W'(i_cfg.depth) + ptp_pkg::DEN_W'(r_q[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_num_x         <= r_q[0] * i_cfg.depth;
            r_num_y         <= r_q[1] * i_cfg.depth;
            r_den           <= n_den;
            r_side.x        <= r_q[0];
            r_side.y        <= r_q[1];
            r_side.z        <= r_q[2];
            r_side.sat      <= r_sat1;
            r_side.proj     <= r_proj1;
            r_side.den_zero <= (n_den == '0);
            r_side.last     <= r_last1;
        end
    end

    assign o_side  = r_side;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den;

endmodule

[src/ptp_div.sv]
`timescale 1ns / 1ps

module ptp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  ptp_pkg::t_side                   i_side,
    input  logic signed [ptp_pkg::NUM_W-1:0] i_num_x,
    input  logic signed [ptp_pkg::NUM_W-1:0] i_num_y,
    input  logic signed [ptp_pkg::DEN_W-1:0] i_den,
    output logic                             o_valid,
    input  logic                             i_stall,
    output ptp_pkg::t_side                   o_side,
    output ptp_pkg::t_coord                  o_screen_x,
    output ptp_pkg::t_coord                  o_screen_y,
    output logic                             o_div_err
);

    localparam int DS  = ptp_pkg::DIV_STAGES;
    localparam int BPS = ptp_pkg::DIV_BITS_PER_STAGE;
    localparam int QW  = ptp_pkg::DIV_Q_W;
    localparam int DW  = ptp_pkg::DEN_W;
    localparam int NS  = DS + 2;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
    } t_dstep;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    ptp_pkg::t_side r_side [NS];
    logic [DW-1:0]  r_den  [DS+1];
    logic           r_neg  [DS+1][2];
    logic           r_ovf  [DS+1][2];
    t_dstep         r_st   [DS+1][2];

    logic signed [ptp_pkg::NUM_W-1:0] w_num [2];
    t_dstep          n_st0 [2];
    logic            n_ovf0[2];
    logic [DW-1:0]   n_den0;

    ptp_pkg::t_coord n_scr [2];
    logic            n_sat;
    ptp_pkg::t_side  n_side;
    ptp_pkg::t_coord r_sx;
    ptp_pkg::t_coord r_sy;
    logic            r_err;

    // Retire BPS quotient bits of a restoring division
    function automatic t_dstep div_step(t_dstep st, logic [DW-1:0] den);
        t_dstep      nx;
        logic [DW:0] trial;
        nx = st;
        for (int b = 0; b < BPS; b++) begin
            trial  = {nx.rem, nx.low[QW-1]};
            nx.low = nx.low << 1;
            if (trial >= {1'b0, den}) begin
                trial  = trial - {1'b0, den};
                nx.quo = {nx.quo[QW-2:0], 1'b1};
            end else begin
                nx.quo = {nx.quo[QW-2:0], 1'b0};
            end
            nx.rem = trial[DW-1:0];
        end
        return nx;
    endfunction

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_en[NS] = !i_stall;
        for (int s = NS - 1; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // Prep: magnitudes, result sign, early overflow when quotient needs more than QW bits
    assign w_num[0] = i_num_x;
    assign w_num[1] = i_num_y;
    assign n_den0   = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    always_comb begin
        logic [ptp_pkg::NUM_W-1:0] mag;
        for (int l = 0; l < 2; l++) begin
            mag = w_num[l][ptp_pkg::NUM_W-1] ? ptp_pkg::NUM_W'(-w_num[l])
                                              : ptp_pkg::NUM_W'(w_num[l]);
            n_ovf0[l]    = ({1'b0, mag[ptp_pkg::NUM_W-1:QW]} >= n_den0);
            n_st0[l].rem = {1'b0, mag[ptp_pkg::NUM_W-1:QW]};
            n_st0[l].low = mag[QW-1:0];
            n_st0[l].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= i_side;
            r_den[0]  <= n_den0;
            for (int l = 0; l < 2; l++) begin
                r_st[0][l]  <= n_st0[l];
                r_ovf[0][l] <= n_ovf0[l];
                r_neg[0][l] <= w_num[l][ptp_pkg::NUM_W-1] ^ i_den[DW-1];
            end
        end
    end

    // Iterate: one stage per BPS quotient bits
    for (genvar k = 1; k <= DS; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
                for (int l = 0; l < 2; l++) begin
                    r_st[k][l]  <= div_step(r_st[k-1][l], r_den[k-1]);
                    r_ovf[k][l] <= r_ovf[k-1][l];
                    r_neg[k][l] <= r_neg[k-1][l];
                end
            end
        end
    end

    // Finish: apply sign, clip, zero when not projecting or denominator is zero
    always_comb begin
        logic [QW-1:0] q;
        n_sat = r_side[DS].sat;
        for (int l = 0; l < 2; l++) begin
            q = r_st[DS][l].quo;
            if (!r_side[DS].proj || r_side[DS].den_zero) begin
                n_scr[l] = '0;
            end else if (!r_neg[DS][l]) begin
                if (r_ovf[DS][l] || q[QW-1]) begin
                    n_scr[l] = ptp_pkg::t_coord'(32'h7fffffff);
                    n_sat    = 1'b1;
                end else begin
                    n_scr[l] = ptp_pkg::t_coord'(q);
                end
            end else begin
                if (r_ovf[DS][l] || (q[QW-1] && (q[QW-2:0] != '0))) begin
                    n_scr[l] = ptp_pkg::t_coord'(32'h80000000);
                    n_sat    = 1'b1;
                end else begin
                    n_scr[l] = ptp_pkg::t_coord'(-q);
                end
            end
        end
        n_side     = r_side[DS];
        n_side.sat = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_side[NS-1] <= n_side;
            r_sx         <= n_scr[0];
            r_sy         <= n_scr[1];
            r_err        <= r_side[DS].proj && r_side[DS].den_zero;
        end
    end

    assign o_side     = r_side[NS-1];
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_div_err  = r_err;

endmodule

[src/point_transform_project.sv]
`timescale 1ns / 1ps

// Affine transform and perspective projection of Q16.16 points. Each point
// passes three stages for the 3x3 multiply-add, rounding and clipping and
// the x*d, y*d products, then 18 stages for the two signed divides by d+z
// (a sign/overflow stage, a 16-stage restoring divider that retires two
// quotient bits per stage, and a sign/clip stage). Throughput is one point
// per cycle; a held output stalls only once every stage is full. Registers
// sit at byte address 8*i on the 64-bit APB port; the user must write them
// only while no point is in flight, as the block itself does not enforce it.
module point_transform_project #(
    parameter int COEF_FRAC_BITS = ptp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptp_pkg::CFG_AW-1:0]    paddr,
    input  logic [ptp_pkg::CFG_DW-1:0]    pwdata,
    output logic [ptp_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  ptp_pkg::t_coord               i_in_x,
    input  ptp_pkg::t_coord               i_in_y,
    input  ptp_pkg::t_coord               i_in_z,
    input  logic                          i_in_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ptp_pkg::t_coord               o_out_x,
    output ptp_pkg::t_coord               o_out_y,
    output ptp_pkg::t_coord               o_out_z,
    output ptp_pkg::t_coord               o_screen_x,
    output ptp_pkg::t_coord               o_screen_y,
    output logic                          o_divide_error,
    output logic                          o_saturated,
    output logic                          o_out_last
);

    localparam logic [ptp_pkg::ROW_W-1:0] ONE = ptp_pkg::ROW_W'(1) << COEF_FRAC_BITS;

    ptp_pkg::t_cfg r_cfg;
    logic [ptp_pkg::REG_IDX_W-1:0] w_idx;
    logic w_wr;

    ptp_pkg::t_side                   w_xf_side;
    logic                             w_xf_valid;
    logic                             w_div_stall;
    logic signed [ptp_pkg::NUM_W-1:0] w_num_x;
    logic signed [ptp_pkg::NUM_W-1:0] w_num_y;
    logic signed [ptp_pkg::DEN_W-1:0] w_den;
    ptp_pkg::t_side                   w_out_side;

    assign w_idx  = paddr[ptp_pkg::CFG_AW-1:ptp_pkg::CFG_AW-ptp_pkg::REG_IDX_W];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= ptp_pkg::MODE_XFORM_PROJ;
            r_cfg.coef_x  <= ONE;
            r_cfg.coef_y  <= ONE << ptp_pkg::COEF_W;
            r_cfg.coef_z  <= ONE << (2 * ptp_pkg::COEF_W);
            r_cfg.shift_x <= '0;
            r_cfg.shift_y <= '0;
            r_cfg.shift_z <= '0;
            r_cfg.depth   <= ptp_pkg::t_coord'(32'h00010000);
        end else if (w_wr) begin
            case (w_idx)
                ptp_pkg::REG_MODE:       r_cfg.mode    <= pwdata[1:0];
                ptp_pkg::REG_COEF_ROW_X: r_cfg.coef_x  <= pwdata[ptp_pkg::ROW_W-1:0];
                ptp_pkg::REG_COEF_ROW_Y: r_cfg.coef_y  <= pwdata[ptp_pkg::ROW_W-1:0];
                ptp_pkg::REG_COEF_ROW_Z: r_cfg.coef_z  <= pwdata[ptp_pkg::ROW_W-1:0];
                ptp_pkg::REG_SHIFT_X:    r_cfg.shift_x <= pwdata[ptp_pkg::COORD_W-1:0];
                ptp_pkg::REG_SHIFT_Y:    r_cfg.shift_y <= pwdata[ptp_pkg::COORD_W-1:0];
                ptp_pkg::REG_SHIFT_Z:    r_cfg.shift_z <= pwdata[ptp_pkg::COORD_W-1:0];
                ptp_pkg::REG_VIEW_DEPTH: r_cfg.depth   <= pwdata[ptp_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (w_idx)
            ptp_pkg::REG_MODE:       prdata = ptp_pkg::CFG_DW'(r_cfg.mode);
            ptp_pkg::REG_COEF_ROW_X: prdata = ptp_pkg::CFG_DW'(r_cfg.coef_x);
            ptp_pkg::REG_COEF_ROW_Y: prdata = ptp_pkg::CFG_DW'(r_cfg.coef_y);
            ptp_pkg::REG_COEF_ROW_Z: prdata = ptp_pkg::CFG_DW'(r_cfg.coef_z);
            ptp_pkg::REG_SHIFT_X:    prdata = ptp_pkg::CFG_DW'(r_cfg.shift_x);
            ptp_pkg::REG_SHIFT_Y:    prdata = ptp_pkg::CFG_DW'(r_cfg.shift_y);
            ptp_pkg::REG_SHIFT_Z:    prdata = ptp_pkg::CFG_DW'(r_cfg.shift_z);
            ptp_pkg::REG_VIEW_DEPTH: prdata = ptp_pkg::CFG_DW'(r_cfg.depth);
            default:                 prdata = '0;
        endcase
    end

    ptp_xform #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .i_last  (i_in_last),
        .i_cfg   (r_cfg),
        .o_valid (w_xf_valid),
        .i_stall (w_div_stall),
        .o_side  (w_xf_side),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den)
    );

    ptp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_xf_valid),
        .o_stall    (w_div_stall),
        .i_side     (w_xf_side),
        .i_num_x    (w_num_x),
        .i_num_y    (w_num_y),
        .i_den      (w_den),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_side     (w_out_side),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_div_err  (o_divide_error)
    );

    assign o_out_x     = w_out_side.x;
    assign o_out_y     = w_out_side.y;
    assign o_out_z     = w_out_side.z;
    assign o_saturated = w_out_side.sat;
    assign o_out_last  = w_out_side.last;

    // Backpressure reaches the input only when the pipe is full up to the output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register is empty");

    // A zero denominator means z cancels the view depth and both screen values are zero
    a_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |->
            ((o_out_z + r_cfg.depth) == '0 && o_screen_x == '0 && o_screen_y == '0))
        else $error("divide error with nonzero denominator or screen values");

    // Transform only never projects
    a_no_proj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.mode == ptp_pkg::MODE_XFORM_ONLY) |->
            (!o_divide_error && o_screen_x == '0 && o_screen_y == '0))
        else $error("projection output in transform only mode");

endmodule

[verif/point_transform_project_checker.sv]
`timescale 1ns / 1ps

module point_transform_project_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   psel,
    input  logic   penable,
    input  logic   pwrite,
    input  logic   pready,
    input  logic [ptp_pkg::CFG_AW-1:0] paddr,
    input  logic [ptp_pkg::CFG_DW-1:0] pwdata,
    input  logic   i_valid,
    input  logic   o_stall,
    input  ptp_pkg::t_coord i_in_x,
    input  ptp_pkg::t_coord i_in_y,
    input  ptp_pkg::t_coord i_in_z,
    input  logic   i_in_last,
    input  logic   o_valid,
    input  logic   i_stall,
    input  ptp_pkg::t_coord o_out_x,
    input  ptp_pkg::t_coord o_out_y,
    input  ptp_pkg::t_coord o_out_z,
    input  ptp_pkg::t_coord o_screen_x,
    input  ptp_pkg::t_coord o_screen_y,
    input  logic   o_divide_error,
    input  logic   o_saturated,
    input  logic   o_out_last,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int CFB = ptp_pkg::COEF_FRAC_BITS_DEF;

    typedef struct packed {
        ptp_pkg::t_coord x, y, z, sx, sy;
        logic   derr, sat, last;
    } t_point_result;

    // Shadow copy of the register file
    logic [1:0]                resolve_unused_dummy_never;
    logic [1:0]                mode_q;
    logic [ptp_pkg::ROW_W-1:0] rows_q [3];
    ptp_pkg::t_coord           shifts_q [3];
    ptp_pkg::t_coord           depth_q;

    t_point_result expected_points[$];

    // Count requests in flight
    always @(posedge i_clk) begin
        if (!i_rst_n)
            o_pending <= 0;
        else
            o_pending <= o_pending + ((i_valid && !o_stall) ? 1 : 0)
                                   - ((o_valid && !i_stall) ? 1 : 0);
    end

    function automatic longint clip32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_point_result transform_point(input ptp_pkg::t_coord x,
                                                      input ptp_pkg::t_coord y,
                                                      input ptp_pkg::t_coord z,
                                                      input logic last);
        t_point_result r;
        longint pin[3];
        longint pq[3];
        longint acc, den;
        logic signed [ptp_pkg::COEF_W-1:0] c;
        logic xf, pj, sat;
        xf  = (mode_q != ptp_pkg::MODE_PROJ_ONLY);
        pj  = (mode_q != ptp_pkg::MODE_XFORM_ONLY);
        sat = 1'b0;
        pin[0] = x;
        pin[1] = y;
        pin[2] = z;
        r = '0;
        for (int j = 0; j < 3; j++) begin
            if (xf) begin
                acc = longint'(shifts_q[j]) <<< CFB;
                for (int k = 0; k < 3; k++) begin
                    c = rows_q[k][ptp_pkg::COEF_W*j +: ptp_pkg::COEF_W];
                    acc += pin[k] * longint'(c);
                end
                acc += longint'(1) <<< (CFB - 1);
                pq[j] = clip32(acc >>> CFB, sat);
            end else begin
                pq[j] = pin[j];
            end
        end
        if (pj) begin
            den = longint'(depth_q) + pq[2];
            if (den == 0) begin
                r.derr = 1'b1;
            end else begin
                r.sx = ptp_pkg::t_coord'(clip32((pq[0] * longint'(depth_q)) / den, sat));
                r.sy = ptp_pkg::t_coord'(clip32((pq[1] * longint'(depth_q)) / den, sat));
            end
        end
        r.x    = ptp_pkg::t_coord'(pq[0]);
        r.y    = ptp_pkg::t_coord'(pq[1]);
        r.z    = ptp_pkg::t_coord'(pq[2]);
        r.sat  = sat;
        r.last = last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    // Track register writes and predict on each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q      <= ptp_pkg::MODE_XFORM_PROJ;
            rows_q[0]   <= 48'h1 << CFB;
            rows_q[1]   <= (48'h1 << CFB) << 16;
            rows_q[2]   <= (48'h1 << CFB) << 32;
            shifts_q[0] <= '0;
            shifts_q[1] <= '0;
            shifts_q[2] <= '0;
            depth_q     <= 32'sd65536;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ptp_pkg::CFG_AW-1:3])
                    ptp_pkg::REG_MODE:       mode_q      <= pwdata[1:0];
                    ptp_pkg::REG_COEF_ROW_X: rows_q[0]   <= pwdata[ptp_pkg::ROW_W-1:0];
                    ptp_pkg::REG_COEF_ROW_Y: rows_q[1]   <= pwdata[ptp_pkg::ROW_W-1:0];
                    ptp_pkg::REG_COEF_ROW_Z: rows_q[2]   <= pwdata[ptp_pkg::ROW_W-1:0];
                    ptp_pkg::REG_SHIFT_X:    shifts_q[0] <= pwdata[31:0];
                    ptp_pkg::REG_SHIFT_Y:    shifts_q[1] <= pwdata[31:0];
                    ptp_pkg::REG_SHIFT_Z:    shifts_q[2] <= pwdata[31:0];
                    ptp_pkg::REG_VIEW_DEPTH: depth_q     <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_points.push_back(transform_point(i_in_x, i_in_y, i_in_z, i_in_last));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_point_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", o_out_x, 0);
            end else begin
                w = expected_points.pop_front();
                if (o_out_x !== w.x) report_mismatch("out_x", o_out_x, w.x);
                if (o_out_y !== w.y) report_mismatch("out_y", o_out_y, w.y);
                if (o_out_z !== w.z) report_mismatch("out_z", o_out_z, w.z);
                if (o_screen_x !== w.sx) report_mismatch("screen_x", o_screen_x, w.sx);
                if (o_screen_y !== w.sy) report_mismatch("screen_y", o_screen_y, w.sy);
                if (o_divide_error !== w.derr)
                    report_mismatch("divide_error", o_divide_error, w.derr);
                if (o_saturated !== w.sat) report_mismatch("saturated", o_saturated, w.sat);
                if (o_out_last !== w.last) report_mismatch("out_last", o_out_last, w.last);
            end
        end
    end

endmodule

[verif/point_transform_project_tb.sv]
`timescale 1ns / 1ps

module point_transform_project_tb;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ptp_pkg::CFG_AW-1:0] paddr;
    logic [ptp_pkg::CFG_DW-1:0] pwdata, prdata;
    logic i_valid, o_stall, i_in_last, o_valid, i_stall;
    ptp_pkg::t_coord i_in_x, i_in_y, i_in_z;
    ptp_pkg::t_coord o_out_x, o_out_y, o_out_z, o_screen_x, o_screen_y;
    logic o_divide_error, o_saturated, o_out_last;
    int fail_count, pending;
    logic calm;

    point_transform_project i_dut (.*);

    point_transform_project_checker i_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output-side stall in random bursts
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [ptp_pkg::REG_IDX_W-1:0] idx, input logic [63:0] val);
        paddr   = ptp_pkg::CFG_AW'(idx) << 3;
        pwdata  = val;
        pwrite  = 1'b1;
        psel    = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold one request until accepted, with optional idle burst before it
    task automatic send_point(input ptp_pkg::t_coord x, input ptp_pkg::t_coord y,
                              input ptp_pkg::t_coord z, input logic last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_in_x    = x;
        i_in_y    = y;
        i_in_z    = z;
        i_in_last = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic ptp_pkg::t_coord rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [47:0] rnd_row();
        logic [47:0] r;
        for (int i = 0; i < 3; i++)
            r[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                          : 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
        return r;
    endfunction

    // Drain all results and let the pipeline settle before a register write
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] m;
        ptp_pkg::t_coord zz;
        calm = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_in_x = '0; i_in_y = '0; i_in_z = '0; i_in_last = 0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default setup, extremes, zero denominator
        send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'sd65536, -32'sd65536, -32'sd65536, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 1'b0);
        for (int md = 0; md < 4; md++) begin
            wait_idle();
            write_reg(ptp_pkg::REG_MODE, 64'(md));
            write_reg(ptp_pkg::REG_COEF_ROW_X, 64'h7FFF_7FFF_7FFF);
            write_reg(ptp_pkg::REG_COEF_ROW_Y, 64'h8000_8000_8000);
            write_reg(ptp_pkg::REG_SHIFT_X, 64'h7FFF_FFFF);
            write_reg(ptp_pkg::REG_SHIFT_Y, 64'h8000_0000);
            write_reg(ptp_pkg::REG_SHIFT_Z, 64'h0);
            write_reg(ptp_pkg::REG_COEF_ROW_Z, 64'h0000_0000_1000);
            write_reg(ptp_pkg::REG_VIEW_DEPTH, 64'h0001_0000);
            send_point(32'h7FFF_FFFF, 32'h8000_0000, -32'sd65536, 1'b1);
            send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
            send_point(32'sd12345, -32'sd999, 32'sd7, 1'b1);
        end
        wait_idle();
        write_reg(ptp_pkg::REG_VIEW_DEPTH, 64'h8000_0000);
        send_point(32'sd1, 32'sd1, 32'sd0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'sd3, 32'h7FFF_FFFF, 1'b1);

        // Random phases, each with a fresh register setting
        for (int ph = 0; ph < 29; ph++) begin
            wait_idle();
            if (ph >= 25) calm = 1'b1;
            m = $urandom_range(0, 3);
            write_reg(ptp_pkg::REG_MODE, 64'(m));
            write_reg(ptp_pkg::REG_COEF_ROW_X, 64'(rnd_row()));
            write_reg(ptp_pkg::REG_COEF_ROW_Y, 64'(rnd_row()));
            write_reg(ptp_pkg::REG_COEF_ROW_Z, 64'(rnd_row()));
            write_reg(ptp_pkg::REG_SHIFT_X, {32'h0, rnd_coord()});
            write_reg(ptp_pkg::REG_SHIFT_Y, {32'h0, rnd_coord()});
            write_reg(ptp_pkg::REG_SHIFT_Z, {32'h0, rnd_coord()});
            write_reg(ptp_pkg::REG_VIEW_DEPTH, {32'h0, rnd_coord()});
            for (int i = 0; i < 50; i++) begin
                // Project-only with z = -d hits the zero denominator
                zz = ($urandom_range(0, 9) == 0) ? -i_chk.depth_q : rnd_coord();
                send_point(rnd_coord(), rnd_coord(), zz, 1'($urandom()));
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
